FILE: rtl/qwt_pkg.sv
// Shared types and constants for the quoted word tokenizer.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package qwt_pkg;

  localparam int unsigned LenBits    = 12;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResCntBits = 2;
  localparam int unsigned FifoDepth  = 8;
  localparam int unsigned FifoPtrBits = 3;
  localparam int unsigned FifoCntBits = 4;

  localparam logic [LenBits-1:0] MaxLenReset = LenBits'(200);

  // Configuration register index (byte address 4*index).
  localparam logic RegIdxMaxLen = 1'b0;

  // Result kinds.
  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindEnd  = 2'd1;
  localparam logic [1:0] KindLine = 2'd2;
  localparam logic [1:0] KindOver = 2'd3;

  // Characters with special meaning.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_WORD    = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } quote_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_done;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           char_out;
    logic [CountBits-1:0] word_number;
    logic                 last;
  } out_item_t;

  typedef out_item_t [MaxResults-1:0] res_vec_t;

  typedef struct packed {
    phase_e               phase;
    quote_e               quote;
    logic                 esc;
    logic [LenBits-1:0]   len;
    logic [CountBits-1:0] count;
  } tok_state_t;

  typedef struct packed {
    logic [FifoCntBits-1:0] count;
    logic                   room;
  } fifo_stat_t;

endpackage

FILE: rtl/qwt_step.sv
// Combinational next-state and result logic for one input byte of the tokenizer.
// Depends on qwt_pkg for the state, item and result types.
module qwt_step (
  input  qwt_pkg::tok_state_t                st_i,
  input  qwt_pkg::in_item_t                  item_i,
  input  logic [qwt_pkg::LenBits-1:0]        max_len_i,
  output qwt_pkg::tok_state_t                st_o,
  output qwt_pkg::res_vec_t                  res_o,
  output logic [qwt_pkg::ResCntBits-1:0]     num_o
);

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  always_comb begin
    qwt_pkg::tok_state_t               s;
    qwt_pkg::res_vec_t                 res;
    logic [qwt_pkg::ResCntBits-1:0]    n;
    logic [7:0]                        c;
    logic                              do_app;
    logic                              do_end;
    logic                              do_stop;
    logic                              do_line;
    logic                              quoted;
    logic                              closing;
    logic                              ended;

    s       = st_i;
    res     = '0;
    n       = '0;
    c       = item_i.char_in;
    do_app  = 1'b0;
    do_end  = 1'b0;
    do_stop = 1'b0;
    do_line = 1'b0;
    ended   = 1'b0;
    quoted  = (st_i.quote != qwt_pkg::Q_NONE);
    closing = (st_i.quote == qwt_pkg::Q_DOUBLE && c == qwt_pkg::ChDquote) ||
              (st_i.quote == qwt_pkg::Q_SINGLE && c == qwt_pkg::ChSquote) ||
              (!quoted && is_space(c));

    if (item_i.line_done) begin
      do_end  = (st_i.phase == qwt_pkg::PH_WORD);
      do_line = 1'b1;
    end else begin
      case (st_i.phase)
        qwt_pkg::PH_BETWEEN: begin
          if (c == qwt_pkg::ChLf) begin
            do_stop = 1'b1;
          end else if (is_space(c)) begin
            s = st_i;
          end else begin
            s.phase = qwt_pkg::PH_WORD;
            s.quote = qwt_pkg::Q_NONE;
            s.esc   = 1'b0;
            s.len   = '0;
            if (c == qwt_pkg::ChDquote) begin
              s.quote = qwt_pkg::Q_DOUBLE;
            end else if (c == qwt_pkg::ChSquote) begin
              s.quote = qwt_pkg::Q_SINGLE;
            end else begin
              do_app = 1'b1;
            end
          end
        end
        qwt_pkg::PH_WORD: begin
          if (quoted && c == qwt_pkg::ChBackslash && !st_i.esc) begin
            s.esc = 1'b1;
          end else if (c == qwt_pkg::ChLf || c == qwt_pkg::ChCr) begin
            do_end  = 1'b1;
            do_stop = (c == qwt_pkg::ChLf);
          end else if (!st_i.esc && closing) begin
            do_end = 1'b1;
          end else begin
            s.esc  = 1'b0;
            do_app = 1'b1;
          end
        end
        default: begin
          s.phase = qwt_pkg::PH_STOPPED;
        end
      endcase
    end

    // Add one byte to the word, or flag overflow and stop the line.
    if (do_app) begin
      if (s.len >= max_len_i) begin
        res[n] = '{kind: qwt_pkg::KindOver, char_out: 8'd0, word_number: s.count, last: 1'b0};
        n = n + 1'b1;
        s.phase = qwt_pkg::PH_STOPPED;
        s.quote = qwt_pkg::Q_NONE;
        s.esc   = 1'b0;
        s.len   = '0;
      end else begin
        s.len  = s.len + 1'b1;
        res[n] = '{kind: qwt_pkg::KindByte, char_out: c, word_number: s.count, last: 1'b0};
        n = n + 1'b1;
      end
    end

    // Word end: a pending backslash goes out first as a literal byte.
    if (do_end) begin
      if (s.esc) begin
        s.esc = 1'b0;
        if (s.len >= max_len_i) begin
          res[n] = '{kind: qwt_pkg::KindOver, char_out: 8'd0, word_number: s.count,
                     last: 1'b0};
          n = n + 1'b1;
          s.phase = qwt_pkg::PH_STOPPED;
          s.quote = qwt_pkg::Q_NONE;
          s.len   = '0;
          ended   = 1'b1;
        end else begin
          s.len  = s.len + 1'b1;
          res[n] = '{kind: qwt_pkg::KindByte, char_out: qwt_pkg::ChBackslash,
                     word_number: s.count, last: 1'b0};
          n = n + 1'b1;
        end
      end
      if (!ended) begin
        if (s.len == '0) begin
          s.phase = qwt_pkg::PH_STOPPED;
          s.quote = qwt_pkg::Q_NONE;
        end else begin
          res[n] = '{kind: qwt_pkg::KindEnd, char_out: 8'd0, word_number: s.count,
                     last: 1'b0};
          n = n + 1'b1;
          if (s.count != '1) begin
            s.count = s.count + 1'b1;
          end
          s.phase = qwt_pkg::PH_BETWEEN;
          s.quote = qwt_pkg::Q_NONE;
          s.len   = '0;
        end
      end
    end

    if (do_stop) begin
      s.phase = qwt_pkg::PH_STOPPED;
      s.quote = qwt_pkg::Q_NONE;
      s.esc   = 1'b0;
      s.len   = '0;
    end

    if (do_line) begin
      res[n] = '{kind: qwt_pkg::KindLine, char_out: 8'd0, word_number: s.count, last: 1'b0};
      n = n + 1'b1;
      s.phase = qwt_pkg::PH_BETWEEN;
      s.quote = qwt_pkg::Q_NONE;
      s.esc   = 1'b0;
      s.len   = '0;
      s.count = '0;
    end

    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end

    st_o  = s;
    res_o = res;
    num_o = n;
  end

endmodule

FILE: rtl/qwt_out_fifo.sv
// Result queue: takes up to three results per cycle, hands out one beat per cycle while the output is not stalled.
// Depends on qwt_pkg for the result types and queue sizes.
module qwt_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  qwt_pkg::res_vec_t              res_i,
  input  logic [qwt_pkg::ResCntBits-1:0] num_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output qwt_pkg::out_item_t             out_item_o,
  output qwt_pkg::fifo_stat_t            stat_o
);

  qwt_pkg::out_item_t mem_q [qwt_pkg::FifoDepth];

  logic [qwt_pkg::FifoPtrBits-1:0] wptr_q, wptr_d;
  logic [qwt_pkg::FifoPtrBits-1:0] rptr_q, rptr_d;
  logic [qwt_pkg::FifoCntBits-1:0] count_q, count_d;
  logic [qwt_pkg::FifoCntBits-1:0] push_cnt;
  logic                            pop;

  assign pop      = out_valid_o && !out_stall_i;
  assign push_cnt = push_i ? qwt_pkg::FifoCntBits'(num_i) : '0;

  always_comb begin
    wptr_d  = wptr_q + qwt_pkg::FifoPtrBits'(push_cnt);
    rptr_d  = rptr_q + qwt_pkg::FifoPtrBits'(pop);
    count_d = count_q + push_cnt - qwt_pkg::FifoCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < qwt_pkg::MaxResults; k++) begin
      if (push_i && qwt_pkg::ResCntBits'(k) < num_i) begin
        mem_q[wptr_q + qwt_pkg::FifoPtrBits'(k)] <= res_i[k];
      end
    end
  end

  assign out_valid_o  = (count_q != '0);
  assign out_item_o   = mem_q[rptr_q];
  // Room for a worst-case burst of results from one byte.
  assign stat_o.count = count_q;
  assign stat_o.room  = (count_q <= qwt_pkg::FifoCntBits'(qwt_pkg::FifoDepth -
                                                          qwt_pkg::MaxResults));

endmodule

FILE: rtl/quoted_word_tokenizer.sv
// An accepted byte waits in the input register until the result queue has room for its
// worst-case burst; the step logic then updates the state and pushes its results.
// Throughput: one byte per cycle while bytes give one result each and the output is
// not stalled; one result leaves per cycle, so bytes with more results stall the input.
// Reset clears the tokenizer state and the result queue and sets the word limit to 200.
module quoted_word_tokenizer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  qwt_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qwt_pkg::out_item_t   out_item_o,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [2:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  output logic [31:0]          prdata_o,
  output logic                 pready_o
);

  logic [qwt_pkg::LenBits-1:0]    max_len_q;
  logic                           in_valid_q;
  qwt_pkg::in_item_t              in_item_q;
  qwt_pkg::tok_state_t            st_q, st_d;
  qwt_pkg::res_vec_t              res;
  logic [qwt_pkg::ResCntBits-1:0] num;
  qwt_pkg::fifo_stat_t            fstat;
  logic                           go;
  logic                           in_take;
  logic                           cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == qwt_pkg::RegIdxMaxLen);
  assign prdata_o = (paddr_i[2] == qwt_pkg::RegIdxMaxLen) ?
                    32'(max_len_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= qwt_pkg::MaxLenReset;
    end else if (cfg_wr) begin
      max_len_q <= pwdata_i[qwt_pkg::LenBits-1:0];
    end
  end

  // The held byte moves on once the queue can take its worst-case burst.
  assign go         = in_valid_q && fstat.room;
  assign in_stall_o = in_valid_q && !fstat.room;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  qwt_step u_step (
    .st_i      (st_q),
    .item_i    (in_item_q),
    .max_len_i (max_len_q),
    .st_o      (st_d),
    .res_o     (res),
    .num_o     (num)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: qwt_pkg::PH_BETWEEN, quote: qwt_pkg::Q_NONE, esc: 1'b0,
                len: '0, count: '0};
    end else if (go) begin
      st_q <= st_d;
    end
  end

  qwt_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (go),
    .res_i       (res),
    .num_i       (num),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .stat_o      (fstat)
  );

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= qwt_pkg::FifoCntBits'(qwt_pkg::FifoDepth))
    else $error("result queue holds more than its depth");

  a_line_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && in_item_q.line_done |=> st_q.count == '0 && st_q.phase == qwt_pkg::PH_BETWEEN)
    else $error("line end did not clear the word count and phase");

  a_idle_word_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase != qwt_pkg::PH_WORD |-> st_q.len == '0 && !st_q.esc)
    else $error("word length or escape left over outside a word");

  a_line_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && in_item_q.line_done |-> num != '0)
    else $error("line end produced no result");
`endif

endmodule

FILE: tb/sv/tokenizer_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the quoted word tokenizer: mirrors the tokenizer state, predicts the
// results of every accepted input beat and compares them with the output beats.
// Depends on qwt_pkg for the payload types, result kinds and special characters.
module tokenizer_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  qwt_pkg::in_item_t    in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  qwt_pkg::out_item_t   out_item_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [2:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  logic [qwt_pkg::LenBits-1:0]   limit_q;
  qwt_pkg::phase_e               phase_q;
  qwt_pkg::quote_e               quote_q;
  logic                          esc_q;
  logic [qwt_pkg::LenBits-1:0]   len_q;
  logic [qwt_pkg::CountBits-1:0] count_q;

  qwt_pkg::out_item_t expected_results[$];
  qwt_pkg::out_item_t step_results[$];

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= qwt_pkg::ChCr);
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] ch);
    qwt_pkg::out_item_t r;
    r.kind        = kind;
    r.char_out    = ch;
    r.word_number = count_q;
    r.last        = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void clear_word();
    quote_q = qwt_pkg::Q_NONE;
    esc_q   = 1'b0;
    len_q   = '0;
  endfunction

  function automatic void stop_line();
    clear_word();
    phase_q = qwt_pkg::PH_STOPPED;
  endfunction

  // An overflowing byte turns into the error result and stops the line.
  function automatic bit add_byte(logic [7:0] c);
    if (len_q >= limit_q) begin
      add_result(qwt_pkg::KindOver, 8'h00);
      stop_line();
      return 1'b0;
    end
    len_q = len_q + 1'b1;
    add_result(qwt_pkg::KindByte, c);
    return 1'b1;
  endfunction

  function automatic void close_word();
    if (esc_q) begin
      esc_q = 1'b0;
      if (!add_byte(qwt_pkg::ChBackslash)) return;
    end
    if (len_q == '0) begin
      stop_line();
      return;
    end
    add_result(qwt_pkg::KindEnd, 8'h00);
    if (count_q != '1) count_q = count_q + 1'b1;
    clear_word();
    phase_q = qwt_pkg::PH_BETWEEN;
  endfunction

  function automatic void tokenize_byte(qwt_pkg::in_item_t it);
    logic [7:0]         c;
    logic [7:0]         close_ch;
    bit                 quoted;
    qwt_pkg::out_item_t r;
    c = it.char_in;
    step_results.delete();
    if (it.line_done) begin
      if (phase_q == qwt_pkg::PH_WORD) close_word();
      add_result(qwt_pkg::KindLine, 8'h00);
      phase_q = qwt_pkg::PH_BETWEEN;
      clear_word();
      count_q = '0;
    end else if (phase_q == qwt_pkg::PH_BETWEEN) begin
      if (c == qwt_pkg::ChLf) begin
        stop_line();
      end else if (is_blank(c)) begin
        // Whitespace between words is skipped.
      end else if (c == qwt_pkg::ChDquote || c == qwt_pkg::ChSquote) begin
        phase_q = qwt_pkg::PH_WORD;
        clear_word();
        quote_q = (c == qwt_pkg::ChDquote) ? qwt_pkg::Q_DOUBLE : qwt_pkg::Q_SINGLE;
      end else begin
        phase_q = qwt_pkg::PH_WORD;
        clear_word();
        void'(add_byte(c));
      end
    end else if (phase_q == qwt_pkg::PH_WORD) begin
      quoted   = quote_q != qwt_pkg::Q_NONE;
      close_ch = (quote_q == qwt_pkg::Q_DOUBLE) ? qwt_pkg::ChDquote : qwt_pkg::ChSquote;
      if (quoted && c == qwt_pkg::ChBackslash && !esc_q) begin
        esc_q = 1'b1;
      end else if (c == qwt_pkg::ChLf || c == qwt_pkg::ChCr) begin
        // Line breaks end the word even right after a backslash.
        close_word();
        if (c == qwt_pkg::ChLf) stop_line();
      end else if (!esc_q && ((quoted && c == close_ch) || (!quoted && is_blank(c)))) begin
        close_word();
      end else begin
        esc_q = 1'b0;
        void'(add_byte(c));
      end
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  function automatic void note_failure(string what, qwt_pkg::out_item_t want,
                                       qwt_pkg::out_item_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("%0t checker: %s: expected kind %0d char %02h word %0d last %0b,",
               $realtime, what, want.kind, want.char_out, want.word_number, want.last,
               " got kind %0d char %02h word %0d last %0b",
               got.kind, got.char_out, got.word_number, got.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    qwt_pkg::out_item_t want;
    if (!rst_ni) begin
      limit_q = qwt_pkg::MaxLenReset;
      phase_q = qwt_pkg::PH_BETWEEN;
      clear_word();
      count_q = '0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      // Results of this edge's input beat cannot leave before the next edges.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          note_failure("result with nothing expected", '0, out_item_i);
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== out_item_i.kind || want.char_out !== out_item_i.char_out ||
              want.word_number !== out_item_i.word_number || want.last !== out_item_i.last)
            note_failure("result mismatch", want, out_item_i);
        end
      end
      if (in_valid_i && !in_stall_i) tokenize_byte(in_item_i);
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == {qwt_pkg::RegIdxMaxLen, 2'b00})
        limit_q = pwdata_i[qwt_pkg::LenBits-1:0];
    end
    pending_o = expected_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the tokenizer testbench: clock, reset, byte stimulus with random gaps, output
// stalls, word limit writes and the verdict. Depends on qwt_pkg, quoted_word_tokenizer
// and tokenizer_checker.
module tb_top;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  qwt_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  qwt_pkg::out_item_t out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int unsigned        fail_count;
  int unsigned        pending;
  bit                 idle_en;
  int                 bytes_sent;
  logic [8:0]         opening_line [24];

  quoted_word_tokenizer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready)
  );

  tokenizer_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= idle_en && ($urandom_range(99) < 10);
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Byte of an unquoted word; the first one must not open a quote.
  function automatic logic [7:0] word_byte(bit first);
    logic [7:0] c;
    do c = any_byte();
    while (c == 8'h20 || (c >= 8'h09 && c <= qwt_pkg::ChCr) ||
           (first && (c == qwt_pkg::ChDquote || c == qwt_pkg::ChSquote)));
    return c;
  endfunction

  function automatic logic [7:0] quoted_byte(logic [7:0] close_ch);
    logic [7:0] c;
    do c = any_byte();
    while (c == close_ch || c == qwt_pkg::ChBackslash || c == qwt_pkg::ChLf ||
           c == qwt_pkg::ChCr);
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0B;
      3: return 8'h0C;
      default: return qwt_pkg::ChCr;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input logic [7:0] c, input logic done);
    while (idle_en && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{char_in: c, line_done: done};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Bytes that give no result may still be in flight, hence the extra cycles.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_limit(input logic [qwt_pkg::LenBits-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {qwt_pkg::RegIdxMaxLen, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly well-formed words with random content, some noise and unclosed quotes.
  task automatic random_line();
    int         n_words;
    int         len;
    int         form;
    logic [7:0] close_ch;
    n_words = $urandom_range(0, 5);
    for (int w = 0; w < n_words; w++) begin
      repeat ($urandom_range(0, 2)) send_item(blank_byte(), 1'b0);
      if ($urandom_range(99) < 8) begin
        send_item(any_byte(), 1'b0);
        continue;
      end
      form = $urandom_range(0, 2);
      len  = ($urandom_range(9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
      if (form == 0) begin
        if (len == 0) len = 1;
        send_item(word_byte(1'b1), 1'b0);
        for (int k = 1; k < len; k++) send_item(word_byte(1'b0), 1'b0);
        send_item(blank_byte(), 1'b0);
      end else begin
        close_ch = (form == 1) ? qwt_pkg::ChDquote : qwt_pkg::ChSquote;
        send_item(close_ch, 1'b0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 10) begin
            send_item(qwt_pkg::ChBackslash, 1'b0);
            send_item(any_byte(), 1'b0);
          end else begin
            send_item(quoted_byte(close_ch), 1'b0);
          end
        end
        if ($urandom_range(99) < 85) send_item(close_ch, 1'b0);
      end
    end
    if ($urandom_range(9) == 0) send_item(qwt_pkg::ChLf, 1'b0);
    send_item(any_byte(), 1'b1);
  endtask

  initial begin
    logic [qwt_pkg::LenBits-1:0] limits [5];
    int                          base;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_en    = 1'b1;
    bytes_sent = 0;
    // Escaped quote, both quote styles, a bare backslash, CR, an empty quoted word with
    // ignored bytes after it, an unclosed quote with a pending backslash, and LF.
    opening_line = '{
      9'h000, 9'h020, {1'b0, qwt_pkg::ChDquote}, 9'h078, {1'b0, qwt_pkg::ChBackslash},
      {1'b0, qwt_pkg::ChDquote}, {1'b0, qwt_pkg::ChDquote}, 9'h009,
      {1'b0, qwt_pkg::ChSquote}, 9'h0FF, {1'b0, qwt_pkg::ChSquote},
      {1'b0, qwt_pkg::ChBackslash}, {1'b0, qwt_pkg::ChCr}, {1'b0, qwt_pkg::ChSquote},
      {1'b0, qwt_pkg::ChSquote}, 9'h041, 9'h1FF, {1'b0, qwt_pkg::ChDquote},
      {1'b0, qwt_pkg::ChBackslash}, 9'h100, 9'h061, {1'b0, qwt_pkg::ChLf},
      9'h062, 9'h17F
    };
    limits = '{3, 200, 1, 12, 4095};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (opening_line[i]) send_item(opening_line[i][7:0], opening_line[i][8]);

    // With a zero limit the first byte of a word overflows.
    set_limit('0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h00, 1'b1);

    // A pending backslash that no longer fits, then an overflow in a later word.
    set_limit(12'd1);
    send_item(qwt_pkg::ChDquote, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(qwt_pkg::ChBackslash, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h79, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h7A, 1'b0);
    send_item(8'h71, 1'b0);
    send_item(8'h00, 1'b1);

    // The second block runs with no idling on either side.
    foreach (limits[i]) begin
      set_limit((i == 3) ? qwt_pkg::LenBits'($urandom_range(2, 9)) : limits[i]);
      idle_en = (i != 1);
      base = bytes_sent;
      while (bytes_sent - base < 70) random_line();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/qwt_pkg.sv
rtl/qwt_step.sv
rtl/qwt_out_fifo.sv
rtl/quoted_word_tokenizer.sv
tb/sv/tokenizer_checker.sv
tb/sv/tb_top.sv
